// ----- design/hbrp_pkg.sv -----
package hbrp_pkg;

  // Number of characters in the range unit prefix "bytes=".
  localparam int PREFIX_LEN = 6;

  localparam logic [7:0] UNIT_PREFIX [PREFIX_LEN] = '{
    8'h62, 8'h79, 8'h74, 8'h65, 8'h73, 8'h3d
  };

  localparam logic [7:0] CHAR_DASH = 8'h2d;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [1:0] {
    OUTCOME_NONE  = 2'd0,
    OUTCOME_OK    = 2'd1,
    OUTCOME_UNSAT = 2'd2
  } outcome_t;

  // Classification of one header byte, as held in the queue.
  typedef struct packed {
    logic                  present;
    logic                  last;
    logic                  is_digit;
    logic [3:0]            digit;
    logic                  is_dash;
    logic [PREFIX_LEN-1:0] prefix_hit;
  } byte_class_t;

  // Parser flags handed to the resolver at the end of a header.
  typedef struct packed {
    logic chars_seen;
    logic failed;
    logic prefix_done;
    logic dash_seen;
    logic start_seen;
    logic end_seen;
  } parse_flags_t;

endpackage

// ----- design/hbrp_front.sv -----
module hbrp_front
  import hbrp_pkg::*;
(
  input  logic [7:0]  header_byte,
  input  logic        byte_present,
  input  logic        is_last,
  output byte_class_t byte_class
);

  logic [7:0] digit_offset;

  assign digit_offset = header_byte - CHAR_ZERO;

  always_comb begin
    byte_class.present  = byte_present;
    byte_class.last     = is_last;
    byte_class.is_digit = (header_byte >= CHAR_ZERO) && (header_byte <= CHAR_NINE);
    byte_class.digit    = digit_offset[3:0];
    byte_class.is_dash  = (header_byte == CHAR_DASH);
    // Compare against every prefix position at once; the parser picks the one it needs.
    for (int i = 0; i < PREFIX_LEN; i++) begin
      byte_class.prefix_hit[i] = (header_byte == UNIT_PREFIX[i]);
    end
  end

endmodule

// ----- design/hbrp_queue.sv -----
module hbrp_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/hbrp_parse.sv -----
module hbrp_parse
  import hbrp_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  byte_class_t            in_class,
  input  logic [VALUE_WIDTH-1:0] in_size,
  output logic                   pop,
  output logic                   snap_valid,
  input  logic                   snap_ready,
  output parse_flags_t           snap_flags,
  output logic [VALUE_WIDTH-1:0] snap_start,
  output logic [VALUE_WIDTH-1:0] snap_end,
  output logic [VALUE_WIDTH-1:0] snap_size
);

  localparam int ACC_W = VALUE_WIDTH + 4;

  logic [2:0]             prefix_matched;
  logic                   chars_seen;
  logic                   dash_seen;
  logic                   start_seen;
  logic                   end_seen;
  logic                   failed;
  logic [VALUE_WIDTH-1:0] start_accum;
  logic [VALUE_WIDTH-1:0] end_accum;

  logic [2:0]             prefix_matched_next;
  logic                   chars_seen_next;
  logic                   dash_seen_next;
  logic                   start_seen_next;
  logic                   end_seen_next;
  logic                   failed_next;
  logic [VALUE_WIDTH-1:0] start_accum_next;
  logic [VALUE_WIDTH-1:0] end_accum_next;

  logic [ACC_W-1:0]       acc_ext;
  logic [ACC_W-1:0]       acc_prod;
  logic                   acc_ovf;
  logic                   prefix_done;
  logic                   snap_free;

  assign snap_free = !snap_valid || snap_ready;
  // A header's last byte waits until the resolver can take the snapshot.
  assign pop = in_valid && (!in_class.last || snap_free);

  assign prefix_done = (prefix_matched == 3'(PREFIX_LEN));

  // Only one number grows at a time, so one multiply-by-ten serves both.
  assign acc_ext  = dash_seen ? ACC_W'(end_accum) : ACC_W'(start_accum);
  assign acc_prod = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(in_class.digit);
  assign acc_ovf  = |acc_prod[ACC_W-1:VALUE_WIDTH];

  always_comb begin
    prefix_matched_next = prefix_matched;
    chars_seen_next     = chars_seen;
    dash_seen_next      = dash_seen;
    start_seen_next     = start_seen;
    end_seen_next       = end_seen;
    failed_next         = failed;
    start_accum_next    = start_accum;
    end_accum_next      = end_accum;
    if (in_class.present) begin
      chars_seen_next = 1'b1;
      if (!failed) begin
        if (!prefix_done) begin
          if (in_class.prefix_hit[prefix_matched]) begin
            prefix_matched_next = prefix_matched + 1'b1;
          end else begin
            failed_next = 1'b1;
          end
        end else if (in_class.is_dash) begin
          if (dash_seen) begin
            failed_next = 1'b1;
          end else begin
            dash_seen_next = 1'b1;
          end
        end else if (in_class.is_digit) begin
          if (dash_seen) begin
            end_seen_next  = 1'b1;
            end_accum_next = acc_prod[VALUE_WIDTH-1:0];
          end else begin
            start_seen_next  = 1'b1;
            start_accum_next = acc_prod[VALUE_WIDTH-1:0];
          end
          if (acc_ovf) begin
            failed_next = 1'b1;
          end
        end else begin
          failed_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_matched <= '0;
      chars_seen     <= 1'b0;
      dash_seen      <= 1'b0;
      start_seen     <= 1'b0;
      end_seen       <= 1'b0;
      failed         <= 1'b0;
      start_accum    <= '0;
      end_accum      <= '0;
      snap_valid     <= 1'b0;
    end else begin
      snap_valid <= (pop && in_class.last) || (snap_valid && !snap_ready);
      if (pop && in_class.last) begin
        prefix_matched <= '0;
        chars_seen     <= 1'b0;
        dash_seen      <= 1'b0;
        start_seen     <= 1'b0;
        end_seen       <= 1'b0;
        failed         <= 1'b0;
        start_accum    <= '0;
        end_accum      <= '0;
      end else if (pop) begin
        prefix_matched <= prefix_matched_next;
        chars_seen     <= chars_seen_next;
        dash_seen      <= dash_seen_next;
        start_seen     <= start_seen_next;
        end_seen       <= end_seen_next;
        failed         <= failed_next;
        start_accum    <= start_accum_next;
        end_accum      <= end_accum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && in_class.last) begin
      snap_flags.chars_seen  <= chars_seen_next;
      snap_flags.failed      <= failed_next;
      snap_flags.prefix_done <= (prefix_matched_next == 3'(PREFIX_LEN));
      snap_flags.dash_seen   <= dash_seen_next;
      snap_flags.start_seen  <= start_seen_next;
      snap_flags.end_seen    <= end_seen_next;
      snap_start             <= start_accum_next;
      snap_end               <= end_accum_next;
      snap_size              <= in_size;
    end
  end

endmodule

// ----- design/hbrp_resolve.sv -----
module hbrp_resolve
  import hbrp_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   snap_valid,
  output logic                   snap_ready,
  input  parse_flags_t           snap_flags,
  input  logic [VALUE_WIDTH-1:0] snap_start,
  input  logic [VALUE_WIDTH-1:0] snap_end,
  input  logic [VALUE_WIDTH-1:0] snap_size,
  output logic                   out_valid,
  input  logic                   out_ready,
  output outcome_t               outcome,
  output logic [VALUE_WIDTH-1:0] first_byte,
  output logic [VALUE_WIDTH-1:0] last_byte
);

  // First step: pick the candidate range and settle the outcomes that need no compare.
  logic                   a_valid;
  logic                   a_done;
  outcome_t               a_code;
  logic [VALUE_WIDTH-1:0] a_first;
  logic [VALUE_WIDTH-1:0] a_last;
  logic [VALUE_WIDTH-1:0] a_size;
  logic [VALUE_WIDTH-1:0] a_size_m1;

  logic                   a_done_next;
  outcome_t               a_code_next;
  logic [VALUE_WIDTH-1:0] a_first_next;
  logic [VALUE_WIDTH-1:0] a_last_next;
  logic [VALUE_WIDTH-1:0] size_m1;

  outcome_t               outcome_next;
  logic [VALUE_WIDTH-1:0] first_byte_next;
  logic [VALUE_WIDTH-1:0] last_byte_next;

  logic                   out_free;
  logic                   a_free;

  assign out_free   = !out_valid || out_ready;
  assign a_free     = !a_valid || out_free;
  assign snap_ready = a_free;
  assign size_m1    = snap_size - 1'b1;

  always_comb begin
    a_done_next  = 1'b0;
    a_code_next  = OUTCOME_UNSAT;
    a_first_next = snap_start;
    a_last_next  = snap_flags.end_seen ? snap_end : size_m1;
    if (!snap_flags.chars_seen) begin
      a_done_next = 1'b1;
      a_code_next = OUTCOME_NONE;
    end else if (snap_flags.failed || !snap_flags.prefix_done || !snap_flags.dash_seen
                 || (snap_size == '0)) begin
      a_done_next = 1'b1;
    end else if (!snap_flags.start_seen) begin
      // Suffix form: the last N bytes, N clamped to the size.
      if (!snap_flags.end_seen || (snap_end == '0)) begin
        a_done_next = 1'b1;
      end
      a_first_next = (snap_end > snap_size) ? '0 : snap_size - snap_end;
      a_last_next  = size_m1;
    end
  end

  always_comb begin
    outcome_next    = a_code;
    first_byte_next = '0;
    last_byte_next  = '0;
    if (!a_done) begin
      if ((a_first > a_last) || (a_first >= a_size)) begin
        outcome_next = OUTCOME_UNSAT;
      end else begin
        outcome_next    = OUTCOME_OK;
        first_byte_next = a_first;
        last_byte_next  = (a_last > a_size_m1) ? a_size_m1 : a_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= snap_valid;
      end
      if (out_free) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && snap_valid) begin
      a_done    <= a_done_next;
      a_code    <= a_code_next;
      a_first   <= a_first_next;
      a_last    <= a_last_next;
      a_size    <= snap_size;
      a_size_m1 <= size_m1;
    end
    if (out_free && a_valid) begin
      outcome    <= outcome_next;
      first_byte <= first_byte_next;
      last_byte  <= last_byte_next;
    end
  end

endmodule

// ----- design/http_byte_range_parser.sv -----
// Data path: the transaction that ends a header passes through the queue, the parser's
// snapshot register and the resolver's first step into the output register.
// Throughput: one header byte per cycle while the queue is not full; the parser's per-byte
// multiply-by-ten and add set that figure, and a header's last byte may wait for the snapshot.
// Reset (rst, synchronous, active high) empties the queue and the pipeline and clears the
// parser; no clearing pass follows, so the block takes input in the first cycle after reset.
module http_byte_range_parser
  import hbrp_pkg::*;
#(
  parameter int VALUE_WIDTH = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,  // [7:0] header_byte, [71:8] resource_size
  input  logic         s_tuser,  // [0] byte_present
  input  logic         s_tlast,  // is_last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata   // [1:0] outcome, [65:2] first_byte, [129:66] last_byte,
                                 // [135:130] zero
);

  // The design is split into a front end and a back end joined by a short queue.
  // The front end classifies each incoming byte (digit, dash, and which prefix
  // characters it matches) and writes the classification, together with the
  // resource size reduced to VALUE_WIDTH bits, into the queue. The back end pops
  // one entry per cycle unless stalled, runs the parser state and, at the end of a header,
  // hands a snapshot to a two-step resolver whose second step is the output register.
  // The queue lets the input side keep accepting while a result waits downstream.

  localparam int ENTRY_W = VALUE_WIDTH + $bits(byte_class_t);

  byte_class_t            in_class;
  logic [ENTRY_W-1:0]     push_entry;
  logic [ENTRY_W-1:0]     pop_entry;
  logic                   queue_not_empty;
  logic                   queue_pop;
  byte_class_t            pop_class;
  logic [VALUE_WIDTH-1:0] pop_size;

  logic                   snap_valid;
  logic                   snap_ready;
  parse_flags_t           snap_flags;
  logic [VALUE_WIDTH-1:0] snap_start;
  logic [VALUE_WIDTH-1:0] snap_end;
  logic [VALUE_WIDTH-1:0] snap_size;

  outcome_t               outcome;
  logic [VALUE_WIDTH-1:0] first_byte;
  logic [VALUE_WIDTH-1:0] last_byte;

  hbrp_front u_front (
    .header_byte  (s_tdata[7:0]),
    .byte_present (s_tuser),
    .is_last      (s_tlast),
    .byte_class   (in_class)
  );

  // Only the low VALUE_WIDTH bits of the resource size take part in the range arithmetic.
  assign push_entry = {s_tdata[8 +: VALUE_WIDTH], in_class};

  hbrp_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && s_tready),
    .push_data (push_entry),
    .not_full  (s_tready),
    .pop       (queue_pop),
    .not_empty (queue_not_empty),
    .pop_data  (pop_entry)
  );

  assign pop_class = pop_entry[$bits(byte_class_t)-1:0];
  assign pop_size  = pop_entry[ENTRY_W-1:$bits(byte_class_t)];

  hbrp_parse #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (queue_not_empty),
    .in_class   (pop_class),
    .in_size    (pop_size),
    .pop        (queue_pop),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_flags (snap_flags),
    .snap_start (snap_start),
    .snap_end   (snap_end),
    .snap_size  (snap_size)
  );

  hbrp_resolve #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_resolve (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_flags (snap_flags),
    .snap_start (snap_start),
    .snap_end   (snap_end),
    .snap_size  (snap_size),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .outcome    (outcome),
    .first_byte (first_byte),
    .last_byte  (last_byte)
  );

  // Offsets are zero-extended to the full 64-bit fields of the result transaction.
  assign m_tdata = {6'b0, 64'(last_byte), 64'(first_byte), outcome};

endmodule
